// ===== src/assert_macros.svh =====
// Assertion macros shared by the compensation block's RTL files.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   `ASSERT_PROP(lbl, clk, rst, !(expr))
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ===== src/bpc_pkg.sv =====
// Types, constants and helpers of the barometric pressure compensation block.
// No dependencies.
package bpc_pkg;

   localparam int QueueDepthDefault = 2;

   localparam logic [2:0] CsrAc1 = 3'd0;
   localparam logic [2:0] CsrAc2 = 3'd1;
   localparam logic [2:0] CsrAc3 = 3'd2;
   localparam logic [2:0] CsrAc4 = 3'd3;
   localparam logic [2:0] CsrB1  = 3'd4;
   localparam logic [2:0] CsrB2  = 3'd5;
   localparam logic [2:0] CsrTmp = 3'd6;
   localparam logic [2:0] CsrOss = 3'd7;

   localparam logic [31:0] B6Offset   = 32'd4000;
   localparam logic [31:0] B4Offset   = 32'd32768;
   localparam logic [15:0] PresScale  = 16'd50000;
   localparam logic [31:0] PCoefSq    = 32'd3038;
   localparam logic [31:0] PCoefLin   = 32'hFFFF_E343;
   localparam logic [31:0] PCoefConst = 32'd3791;

   typedef struct packed {
      logic [15:0] raw_temperature;
      logic [18:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pressure_pa;
      logic signed [15:0] temperature_tenths;
      logic               divide_fault;
   } rsp_type;

   typedef struct packed {
      logic [15:0] ac1;
      logic [15:0] ac2;
      logic [15:0] ac3;
      logic [15:0] ac4;
      logic [15:0] b1;
      logic [15:0] b2;
      logic [15:0] ac5;
      logic [15:0] ac6;
      logic [15:0] mc;
      logic [15:0] md;
      logic [1:0]  oss;
   } cfg_type;

   function automatic logic [31:0] sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

// ===== src/bpc_front.sv =====
// Front end: request queue that decouples acceptance from the datapath.
// Depends on bpc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bpc_front #(
   parameter int Depth = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bpc_pkg::req_type req_data,
   input  logic             pop,
   output logic             q_valid,
   output bpc_pkg::req_type q_data
);
   import bpc_pkg::*;

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   req_type           mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              push, pop_do;

   assign req_stall = (count_ff == CntW'(Depth));
   assign q_valid   = (count_ff != '0);
   assign q_data    = mem_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop_do    = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_do) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CntW'(push) - CntW'(pop_do);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_data;
      end
   end

   `ASSERT_PROP(a_count_bound, clock, reset, count_ff <= CntW'(Depth))
   `ASSERT_PROP(a_count_step, clock, reset, !reset |=> count_ff == $past(count_ff) + CntW'($past(push)) - CntW'($past(pop_do)))
   `ASSERT_PROP(a_head_holds, clock, reset, (!reset && q_valid && !pop) |=> q_data == $past(q_data))

endmodule

// ===== src/bpc_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// No dependencies; carries a sideband word alongside each division.
module bpc_div #(
   parameter int Width     = 32,
   parameter int SideWidth = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [Width-1:0]     dividend,
   input  logic [Width-1:0]     divisor,
   input  logic [SideWidth-1:0] side_in,
   output logic                 out_valid,
   output logic [Width-1:0]     quotient,
   output logic [SideWidth-1:0] side_out
);

   logic                 valid_ff [Width];
   logic [Width-1:0]     rem_ff   [Width];
   logic [Width-1:0]     quo_ff   [Width];
   logic [Width-1:0]     dvs_ff   [Width];
   logic [SideWidth-1:0] side_ff  [Width];
   logic [Width-1:0]     rem_in   [Width];
   logic [Width-1:0]     quo_in   [Width];

   always_comb begin
      logic [Width:0]   trial;
      logic [Width:0]   diff;
      logic [Width-1:0] prev_rem;
      logic [Width-1:0] prev_quo;
      logic [Width-1:0] prev_dvs;
      for (int s = 0; s < Width; s++) begin
         if (s == 0) begin
            prev_rem = '0;
            prev_quo = dividend;
            prev_dvs = divisor;
         end else begin
            prev_rem = rem_ff[s-1];
            prev_quo = quo_ff[s-1];
            prev_dvs = dvs_ff[s-1];
         end
         trial = {prev_rem, prev_quo[Width-1]};
         diff  = trial - {1'b0, prev_dvs};
         if (trial >= {1'b0, prev_dvs}) begin
            rem_in[s] = diff[Width-1:0];
            quo_in[s] = {prev_quo[Width-2:0], 1'b1};
         end else begin
            rem_in[s] = trial[Width-1:0];
            quo_in[s] = {prev_quo[Width-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < Width; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < Width; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= rem_in[0];
         quo_ff[0]  <= quo_in[0];
         dvs_ff[0]  <= divisor;
         side_ff[0] <= side_in;
         for (int s = 1; s < Width; s++) begin
            rem_ff[s]  <= rem_in[s];
            quo_ff[s]  <= quo_in[s];
            dvs_ff[s]  <= dvs_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = valid_ff[Width-1];
   assign quotient  = quo_ff[Width-1];
   assign side_out  = side_ff[Width-1];

endmodule

// ===== src/bpc_back.sv =====
// Back end: the compensation pipeline for temperature and pressure.
// Depends on bpc_pkg and bpc_div; advances as a whole when en is high.
module bpc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  bpc_pkg::req_type in_data,
   input  bpc_pkg::cfg_type cfg,
   output logic             out_valid,
   output bpc_pkg::rsp_type out_data
);
   import bpc_pkg::*;

   localparam int DivW   = 32;
   localparam int Side1W = 19 + 32 + 2;
   localparam int Side2W = 2 + 16;

   logic [31:0] s1_prod_ff, s1_prod_in;
   logic [18:0] s1_up_ff;
   logic [31:0] s2_x1_ff, s2_x1_in, s2_den_ff, s2_den_in;
   logic [18:0] s2_up_ff;
   logic [31:0] s3_num_ff, s3_num_in, s3_dvs_ff, s3_dvs_in;
   logic [Side1W-1:0] s3_side_ff, s3_side_in;

   logic              d1_valid;
   logic [31:0]       d1_quo;
   logic [Side1W-1:0] d1_side;

   logic [31:0] s4_x2_ff, s4_x2_in, s4_x1_ff;
   logic [31:0] s5_b5_ff, s5_b5_in;
   logic [31:0] s6_b6_ff, s6_b6_in, s6_sum8;
   logic [15:0] s6_temp_in;
   logic [31:0] s7_sqp_ff, s7_sqp_in, s7_p2_ff, s7_p2_in, s7_p3_ff, s7_p3_in;
   logic [31:0] s8_sq_ff, s8_sq_in, s8_x1b_ff, s8_x1b_in, s8_x1c_ff, s8_x1c_in;
   logic [31:0] s9_m1_ff, s9_m1_in, s9_m2_ff, s9_m2_in, s9_x1b_ff, s9_x1c_ff;
   logic [31:0] s10_x3a_ff, s10_x3a_in, s10_sum_ff, s10_sum_in;
   logic [31:0] s11_t_ff, s11_t_in, s11_x3_ff, s11_x3_in, s11_sum2;
   logic [31:0] s12_b3p_ff, s12_b3p_in, s12_x3p_ff, s12_x3p_in;
   logic [31:0] s13_b3_ff, s13_b3_in, s13_b3r, s13_prod;
   logic [16:0] s13_b4_ff, s13_b4_in;
   logic [31:0] s14_diff_ff, s14_diff_in;
   logic [16:0] s14_b4_ff;
   logic        s14_f_ff, s14_f_in;
   logic [31:0] s15_b7_ff, s15_b7_in;
   logic [16:0] s15_b4_ff;
   logic        s15_f_ff;

   logic [18:0] up_ff [4:13];
   logic        tz_ff [4:13];
   logic [15:0] tp_ff [6:15];

   logic              d2_valid;
   logic [31:0]       d2_quo, d2_dividend;
   logic [Side2W-1:0] d2_side;

   logic [31:0] s16_p_ff, s16_p_in;
   logic [31:0] s17_aa_ff, s17_aa_in, s17_m3_ff, s17_m3_in, s17_p_ff, s17_a;
   logic [31:0] s18_x1_ff, s18_x1_in, s18_x2_ff, s18_x2_in, s18_p_ff;
   logic [31:0] s19_s_ff, s19_s_in, s19_p_ff;
   logic [31:0] s20_p_ff, s20_p_in;
   logic [15:0] s20_t_ff, s20_t_in;
   logic        s20_f_ff;
   logic [15:0] tl_ff [16:19];
   logic        fl_ff [16:19];

   logic        v_ff [1:20];
   logic        v_in [1:20];

   logic [16:0] s1_diff;
   logic [33:0] s1_full;

   always_comb begin
      s1_diff    = $signed({1'b0, in_data.raw_temperature}) - $signed({1'b0, cfg.ac6});
      s1_full    = $signed(s1_diff) * $signed({1'b0, cfg.ac5});
      s1_prod_in = s1_full[31:0];

      s2_x1_in  = 32'($signed(s1_prod_ff) >>> 15);
      s2_den_in = s2_x1_in + sext16(cfg.md);

      s3_num_in  = {{5{cfg.mc[15]}}, cfg.mc, 11'b0};
      if (cfg.mc[15]) begin
         s3_num_in = ~s3_num_in + 32'd1;
      end
      s3_dvs_in  = s2_den_ff[31] ? (~s2_den_ff + 32'd1) : s2_den_ff;
      s3_side_in = {s2_up_ff, s2_x1_ff, cfg.mc[15] ^ s2_den_ff[31], s2_den_ff == '0};

      s4_x2_in = d1_side[1] ? (~d1_quo + 32'd1) : d1_quo;
      s5_b5_in = s4_x1_ff + s4_x2_ff;

      s6_sum8    = s5_b5_ff + 32'd8;
      s6_temp_in = s6_sum8[19:4];
      s6_b6_in   = s5_b5_ff - B6Offset;

      s7_sqp_in = s6_b6_ff * s6_b6_ff;
      s7_p2_in  = sext16(cfg.ac2) * s6_b6_ff;
      s7_p3_in  = sext16(cfg.ac3) * s6_b6_ff;

      s8_sq_in  = 32'($signed(s7_sqp_ff) >>> 12);
      s8_x1b_in = 32'($signed(s7_p2_ff) >>> 11);
      s8_x1c_in = 32'($signed(s7_p3_ff) >>> 13);

      s9_m1_in = sext16(cfg.b2) * s8_sq_ff;
      s9_m2_in = sext16(cfg.b1) * s8_sq_ff;

      s10_x3a_in = 32'($signed(s9_m1_ff) >>> 11) + s9_x1b_ff;
      s10_sum_in = s9_x1c_ff + 32'($signed(s9_m2_ff) >>> 16);

      s11_t_in  = {{14{cfg.ac1[15]}}, cfg.ac1, 2'b00} + s10_x3a_ff;
      s11_sum2  = s10_sum_ff + 32'd2;
      s11_x3_in = 32'($signed(s11_sum2) >>> 2);

      s12_b3p_in = (s11_t_ff << cfg.oss) + 32'd2;
      s12_x3p_in = s11_x3_ff + B4Offset;

      s13_b3r   = s12_b3p_ff + (s12_b3p_ff[31] ? 32'd3 : 32'd0);
      s13_b3_in = 32'($signed(s13_b3r) >>> 2);
      s13_prod  = {16'b0, cfg.ac4} * s12_x3p_ff;
      s13_b4_in = s13_prod[31:15];

      s14_diff_in = {13'b0, up_ff[13]} - s13_b3_ff;
      s14_f_in    = tz_ff[13] || (s13_b4_ff == '0);

      s15_b7_in = s14_diff_ff * {16'b0, PresScale >> cfg.oss};

      d2_dividend = s15_b7_ff[31] ? s15_b7_ff : {s15_b7_ff[30:0], 1'b0};

      s16_p_in = d2_side[17] ? {d2_quo[30:0], 1'b0} : d2_quo;

      s17_a     = 32'($signed(s16_p_ff) >>> 8);
      s17_aa_in = s17_a * s17_a;
      s17_m3_in = PCoefLin * s16_p_ff;

      s18_x1_in = s17_aa_ff * PCoefSq;
      s18_x2_in = 32'($signed(s17_m3_ff) >>> 16);

      s19_s_in = 32'($signed(s18_x1_ff) >>> 16) + s18_x2_ff + PCoefConst;

      s20_p_in = fl_ff[19] ? '0 : s19_p_ff + 32'($signed(s19_s_ff) >>> 4);
      s20_t_in = fl_ff[19] ? '0 : tl_ff[19];

      v_in[1] = in_valid;
      for (int k = 2; k <= 20; k++) begin
         v_in[k] = v_ff[k-1];
      end
      v_in[4]  = d1_valid;
      v_in[16] = d2_valid;
   end

   bpc_div #(.Width(DivW), .SideWidth(Side1W)) u_div_temp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v_ff[3]),
      .dividend  (s3_num_ff),
      .divisor   (s3_dvs_ff),
      .side_in   (s3_side_ff),
      .out_valid (d1_valid),
      .quotient  (d1_quo),
      .side_out  (d1_side)
   );

   bpc_div #(.Width(DivW), .SideWidth(Side2W)) u_div_pres (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v_ff[15]),
      .dividend  (d2_dividend),
      .divisor   ({15'b0, s15_b4_ff}),
      .side_in   ({s15_b7_ff[31], s15_f_ff, tp_ff[15]}),
      .out_valid (d2_valid),
      .quotient  (d2_quo),
      .side_out  (d2_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= 20; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         for (int k = 1; k <= 20; k++) begin
            v_ff[k] <= v_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_prod_ff <= s1_prod_in;
         s1_up_ff   <= in_data.raw_pressure;
         s2_x1_ff   <= s2_x1_in;
         s2_den_ff  <= s2_den_in;
         s2_up_ff   <= s1_up_ff;
         s3_num_ff  <= s3_num_in;
         s3_dvs_ff  <= s3_dvs_in;
         s3_side_ff <= s3_side_in;

         s4_x2_ff  <= s4_x2_in;
         s4_x1_ff  <= d1_side[33:2];
         up_ff[4]  <= d1_side[52:34];
         tz_ff[4]  <= d1_side[0];
         for (int k = 5; k <= 13; k++) begin
            up_ff[k] <= up_ff[k-1];
            tz_ff[k] <= tz_ff[k-1];
         end
         s5_b5_ff  <= s5_b5_in;
         s6_b6_ff  <= s6_b6_in;
         tp_ff[6]  <= s6_temp_in;
         for (int k = 7; k <= 15; k++) begin
            tp_ff[k] <= tp_ff[k-1];
         end
         s7_sqp_ff  <= s7_sqp_in;
         s7_p2_ff   <= s7_p2_in;
         s7_p3_ff   <= s7_p3_in;
         s8_sq_ff   <= s8_sq_in;
         s8_x1b_ff  <= s8_x1b_in;
         s8_x1c_ff  <= s8_x1c_in;
         s9_m1_ff   <= s9_m1_in;
         s9_m2_ff   <= s9_m2_in;
         s9_x1b_ff  <= s8_x1b_ff;
         s9_x1c_ff  <= s8_x1c_ff;
         s10_x3a_ff <= s10_x3a_in;
         s10_sum_ff <= s10_sum_in;
         s11_t_ff   <= s11_t_in;
         s11_x3_ff  <= s11_x3_in;
         s12_b3p_ff <= s12_b3p_in;
         s12_x3p_ff <= s12_x3p_in;
         s13_b3_ff  <= s13_b3_in;
         s13_b4_ff  <= s13_b4_in;
         s14_diff_ff <= s14_diff_in;
         s14_b4_ff  <= s13_b4_ff;
         s14_f_ff   <= s14_f_in;
         s15_b7_ff  <= s15_b7_in;
         s15_b4_ff  <= s14_b4_ff;
         s15_f_ff   <= s14_f_ff;

         s16_p_ff  <= s16_p_in;
         tl_ff[16] <= d2_side[15:0];
         fl_ff[16] <= d2_side[16];
         for (int k = 17; k <= 19; k++) begin
            tl_ff[k] <= tl_ff[k-1];
            fl_ff[k] <= fl_ff[k-1];
         end
         s17_aa_ff <= s17_aa_in;
         s17_m3_ff <= s17_m3_in;
         s17_p_ff  <= s16_p_ff;
         s18_x1_ff <= s18_x1_in;
         s18_x2_ff <= s18_x2_in;
         s18_p_ff  <= s17_p_ff;
         s19_s_ff  <= s19_s_in;
         s19_p_ff  <= s18_p_ff;
         s20_p_ff  <= s20_p_in;
         s20_t_ff  <= s20_t_in;
         s20_f_ff  <= fl_ff[19];
      end
   end

   always_comb begin
      out_valid                   = v_ff[20];
      out_data.pressure_pa        = s20_p_ff;
      out_data.temperature_tenths = s20_t_ff;
      out_data.divide_fault       = s20_f_ff;
   end

endmodule

// ===== src/barometric_pressure_compensation.sv =====
// Top level of the barometric pressure compensation block.
// Depends on bpc_pkg, bpc_front, bpc_back and assert_macros.svh.
//
//   Channel  Ports                          Direction  Contents
//   req      req_valid req_stall req_data   in         raw temperature and pressure
//   rsp      rsp_valid rsp_stall rsp_data   out        pressure, temperature, fault
//   csr      csr_we csr_index csr_wdata     in         calibration and oversampling
//
// One request is taken per cycle unless a stalled result holds the datapath; a
// result passes the two 32-stage pipelined dividers and the multiply stages.
// Reset empties the queue and zeroes the pipeline valid bits and the configuration.
// A stalled result freezes the whole datapath; the request queue keeps accepting
// until it is full.
`include "assert_macros.svh"
module barometric_pressure_compensation #(
   parameter int QueueDepth = bpc_pkg::QueueDepthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bpc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bpc_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_wdata
);
   import bpc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    advance, q_valid, back_valid;
   req_type q_data;
   rsp_type back_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CsrAc1: cfg_in.ac1 = csr_wdata[15:0];
            CsrAc2: cfg_in.ac2 = csr_wdata[15:0];
            CsrAc3: cfg_in.ac3 = csr_wdata[15:0];
            CsrAc4: cfg_in.ac4 = csr_wdata[15:0];
            CsrB1:  cfg_in.b1  = csr_wdata[15:0];
            CsrB2:  cfg_in.b2  = csr_wdata[15:0];
            CsrTmp: begin
               cfg_in.ac5 = csr_wdata[63:48];
               cfg_in.ac6 = csr_wdata[47:32];
               cfg_in.mc  = csr_wdata[31:16];
               cfg_in.md  = csr_wdata[15:0];
            end
            CsrOss: cfg_in.oss = csr_wdata[1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = advance ? back_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= back_data;
      end
   end

   bpc_front #(.Depth(QueueDepth)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .pop       (advance),
      .q_valid   (q_valid),
      .q_data    (q_data)
   );

   bpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (q_valid),
      .in_data   (q_data),
      .cfg       (cfg_ff),
      .out_valid (back_valid),
      .out_data  (back_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_PROP(a_fault_zero, clock, reset, (rsp_valid_ff && rsp_data_ff.divide_fault) |-> (rsp_data_ff.pressure_pa == '0 && rsp_data_ff.temperature_tenths == '0))
   `ASSERT_PROP(a_held_result, clock, reset, (!reset && rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
   `ASSERT_NEVER(a_lost_result, clock, reset, back_valid && !advance && !rsp_valid_ff)

endmodule
